// File: design/irc_lp_pkg.sv
// Package for the IRC line parser: result word layout, character codes,
// keyword table and the keyword match function. No dependencies.
package irc_lp_pkg;

  localparam int unsigned KW_BYTES  = 7;
  localparam int unsigned KW_COUNT  = 32;
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned Q_DEPTH   = 8;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_LVL_W   = $clog2(Q_DEPTH + 1);
  localparam int unsigned Q_ROOM_LVL = Q_DEPTH - MAX_RES;

  localparam logic [5:0] PARAM_MAX = 6'd63;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    KIND_CMD      = 2'd0,
    KIND_BYTE     = 2'd1,
    KIND_PARAM_END = 2'd2,
    KIND_MSG_END  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_LINE_START = 2'd0,
    PH_PREFIX     = 2'd1,
    PH_COMMAND    = 2'd2,
    PH_PARAMS     = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [5:0] command_code;
    logic [5:0] param_index;
    logic       is_trailing;
    logic       last;
  } res_t;

  // Up to three result words produced by one input byte.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [MAX_RES-1:0] res;
  } push_t;

  typedef struct packed {
    logic [Q_LVL_W-1:0] level;
    logic               room;
  } q_status_t;

  // The keyword buffer shifts bytes in from the right, so the first byte of
  // the token ends up most significant, just as in a string literal.
  localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
    56'("PASS"), 56'("NICK"), 56'("USER"), 56'("SERVER"),
    56'("OPER"), 56'("QUIT"), 56'("SQUIT"), 56'("JOIN"),
    56'("PART"), 56'("MODE"), 56'("TOPIC"), 56'("NAMES"),
    56'("LIST"), 56'("INVITE"), 56'("KICK"), 56'("VERSION"),
    56'("STATS"), 56'("LINKS"), 56'("TIME"), 56'("CONNECT"),
    56'("TRACE"), 56'("ADMIN"), 56'("INFO"), 56'("PRIVMSG"),
    56'("NOTICE"), 56'("WHO"), 56'("WHOIS"), 56'("WHOWAS"),
    56'("KILL"), 56'("PING"), 56'("PONG"), 56'("ERROR")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd4, 4'd5, 4'd4,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7,
    4'd5, 4'd5, 4'd4, 4'd7, 4'd5, 4'd5, 4'd4, 4'd7,
    4'd6, 4'd3, 4'd5, 4'd6, 4'd4, 4'd4, 4'd4, 4'd5
  };

  function automatic logic [5:0] kw_match(input logic [55:0] text, input logic [3:0] len);
    logic [5:0] code;
    code = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
        code = 6'(i + 1);
      end
    end
    return code;
  endfunction

  function automatic res_t make_res(input kind_e kind, input logic [7:0] data,
                                    input logic [5:0] code, input logic [5:0] idx,
                                    input logic trl, input logic lst);
    res_t r;
    r.kind         = kind;
    r.data_byte    = data;
    r.command_code = code;
    r.param_index  = idx;
    r.is_trailing  = trl;
    r.last         = lst;
    return r;
  endfunction

endpackage

// File: design/irc_lp_if.sv
// Handshake interfaces of the IRC line parser: the byte input channel and
// the result channel. Depends on nothing.
interface irc_lp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface irc_lp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [5:0] command_code;
  logic [5:0] param_index;
  logic       is_trailing;
  logic       last;

  modport source (output valid, output kind, output data_byte, output command_code,
                  output param_index, output is_trailing, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input command_code,
                input param_index, input is_trailing, input last, output ready);
endinterface

// File: design/irc_lp_parse.sv
// Input byte register and line parsing logic of the IRC line parser.
// Produces up to three result words per byte. Uses irc_lp_pkg, irc_lp_if.
module irc_lp_parse
  import irc_lp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  irc_lp_byte_if.sink   in_i,
  input  q_status_t     q_stat_i,
  output push_t         push_o
);

  logic        vld_q, vld_d;
  logic [7:0]  byte_q;
  logic        advance;

  logic        cr_q, cr_d;
  phase_e      phase_q, phase_d;
  logic [55:0] kbuf_q, kbuf_d;
  logic [3:0]  klen_q, klen_d;
  logic [5:0]  pcnt_q, pcnt_d;
  logic        has_q, has_d;
  logic        trl_q, trl_d;
  logic        lsp_q, lsp_d;
  logic [5:0]  cmd_q, cmd_d;

  res_t [MAX_RES-1:0] res;
  logic [1:0]  n;

  // A byte leaves the input register only when the queue can take the worst
  // case of three words.
  assign advance  = vld_q && q_stat_i.room;
  assign in_i.ready = !vld_q || q_stat_i.room;
  assign vld_d    = in_i.valid ? 1'b1 : (advance ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= in_i.ready ? vld_d : vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
    end
  end

  always_comb begin
    logic [5:0] code;
    logic [5:0] pinc;
    code    = cmd_q;
    pinc    = (pcnt_q != PARAM_MAX) ? pcnt_q + 6'd1 : pcnt_q;
    res     = '0;
    n       = 2'd0;
    cr_d    = cr_q;
    phase_d = phase_q;
    kbuf_d  = kbuf_q;
    klen_d  = klen_q;
    pcnt_d  = pcnt_q;
    has_d   = has_q;
    trl_d   = trl_q;
    lsp_d   = lsp_q;

    if (byte_q == CH_CR) begin
      cr_d = 1'b1;
    end else if (byte_q == CH_LF && cr_q) begin
      case (phase_q)
        PH_PREFIX, PH_COMMAND: begin
          code = (phase_q == PH_COMMAND) ? kw_match(kbuf_q, klen_q) : 6'd0;
          res[0] = make_res(KIND_CMD, 8'd0, code, 6'd0, 1'b0, 1'b0);
          res[1] = make_res(KIND_MSG_END, 8'd0, code, pcnt_q, 1'b0, 1'b1);
          n = 2'd2;
        end
        PH_PARAMS: begin
          if (trl_q) begin
            // The trailing parameter gets a space appended unless it ends in one.
            if (!lsp_q) begin
              res[n] = make_res(KIND_BYTE, CH_SPACE, code, pcnt_q, 1'b1, 1'b0);
              n = n + 2'd1;
            end
            res[n] = make_res(KIND_PARAM_END, 8'd0, code, pcnt_q, 1'b1, 1'b0);
            n = n + 2'd1;
            res[n] = make_res(KIND_MSG_END, 8'd0, code, pinc, 1'b0, 1'b1);
            n = n + 2'd1;
          end else if (has_q) begin
            res[0] = make_res(KIND_PARAM_END, 8'd0, code, pcnt_q, 1'b0, 1'b0);
            res[1] = make_res(KIND_MSG_END, 8'd0, code, pinc, 1'b0, 1'b1);
            n = 2'd2;
          end else begin
            res[0] = make_res(KIND_MSG_END, 8'd0, code, pcnt_q, 1'b0, 1'b1);
            n = 2'd1;
          end
        end
        default: begin
        end
      endcase
      cr_d    = 1'b0;
      phase_d = PH_LINE_START;
      kbuf_d  = '0;
      klen_d  = '0;
      pcnt_d  = '0;
      has_d   = 1'b0;
      trl_d   = 1'b0;
      lsp_d   = 1'b0;
      code    = 6'd0;
    end else begin
      case (phase_q)
        PH_LINE_START: begin
          if (byte_q == CH_COLON) begin
            phase_d = PH_PREFIX;
          end else if (byte_q == CH_SPACE) begin
            code    = 6'd0;
            res[0]  = make_res(KIND_CMD, 8'd0, code, 6'd0, 1'b0, 1'b0);
            n       = 2'd1;
            phase_d = PH_PARAMS;
          end else begin
            kbuf_d  = {48'd0, byte_q};
            klen_d  = 4'd1;
            phase_d = PH_COMMAND;
          end
        end
        PH_PREFIX: begin
          if (byte_q == CH_SPACE) begin
            phase_d = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          if (byte_q == CH_SPACE) begin
            code    = kw_match(kbuf_q, klen_q);
            res[0]  = make_res(KIND_CMD, 8'd0, code, 6'd0, 1'b0, 1'b0);
            n       = 2'd1;
            phase_d = PH_PARAMS;
          end else if (klen_q < 4'(KW_BYTES)) begin
            kbuf_d = {kbuf_q[47:0], byte_q};
            klen_d = klen_q + 4'd1;
          end else begin
            // Marks the token as too long to be a keyword.
            klen_d = 4'(KW_BYTES + 1);
          end
        end
        default: begin
          n = 2'd1;
          if (trl_q) begin
            res[0] = make_res(KIND_BYTE, byte_q, code, pcnt_q, 1'b1, 1'b0);
            lsp_d  = (byte_q == CH_SPACE);
          end else if (byte_q == CH_SPACE) begin
            res[0] = make_res(KIND_PARAM_END, 8'd0, code, pcnt_q, 1'b0, 1'b0);
            pcnt_d = pinc;
            has_d  = 1'b0;
          end else if (byte_q == CH_COLON && !has_q) begin
            trl_d  = 1'b1;
            lsp_d  = 1'b0;
            res[0] = make_res(KIND_BYTE, byte_q, code, pcnt_q, 1'b1, 1'b0);
          end else begin
            has_d  = 1'b1;
            res[0] = make_res(KIND_BYTE, byte_q, code, pcnt_q, 1'b0, 1'b0);
          end
        end
      endcase
    end
    cmd_d = code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q    <= 1'b0;
      phase_q <= PH_LINE_START;
      kbuf_q  <= '0;
      klen_q  <= '0;
      pcnt_q  <= '0;
      has_q   <= 1'b0;
      trl_q   <= 1'b0;
      lsp_q   <= 1'b0;
      cmd_q   <= '0;
    end else if (advance) begin
      cr_q    <= cr_d;
      phase_q <= phase_d;
      kbuf_q  <= kbuf_d;
      klen_q  <= klen_d;
      pcnt_q  <= pcnt_d;
      has_q   <= has_d;
      trl_q   <= trl_d;
      lsp_q   <= lsp_d;
      cmd_q   <= cmd_d;
    end
  end

  assign push_o.cnt = advance ? n : 2'd0;
  assign push_o.res = res;

endmodule

// File: design/irc_lp_outq.sv
// Result queue of the IRC line parser: takes up to three words per cycle and
// hands out one per cycle while out_o is ready. Uses irc_lp_pkg, irc_lp_if.
module irc_lp_outq
  import irc_lp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  push_t         push_i,
  output q_status_t     q_stat_o,
  irc_lp_res_if.source  out_o
);

  res_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d;
  logic [Q_PTR_W-1:0] rd_q, rd_d;
  logic [Q_LVL_W-1:0] lvl_q, lvl_d;
  logic               pop;
  res_t               head;

  assign head = mem[rd_q];
  assign pop  = out_o.valid && out_o.ready;
  assign wr_d = wr_q + Q_PTR_W'(push_i.cnt);
  assign rd_d = rd_q + Q_PTR_W'(pop);
  assign lvl_d = lvl_q + Q_LVL_W'(push_i.cnt) - Q_LVL_W'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < push_i.cnt) begin
        mem[wr_q + Q_PTR_W'(k)] <= push_i.res[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  assign q_stat_o.level = lvl_q;
  assign q_stat_o.room  = (lvl_q <= Q_LVL_W'(Q_ROOM_LVL));

  assign out_o.valid        = (lvl_q != '0);
  assign out_o.kind         = head.kind;
  assign out_o.data_byte    = head.data_byte;
  assign out_o.command_code = head.command_code;
  assign out_o.param_index  = head.param_index;
  assign out_o.is_trailing  = head.is_trailing;
  assign out_o.last         = head.last;

endmodule

// File: design/irc_line_parser.sv
// Top level of the IRC line parser. Uses irc_lp_pkg, irc_lp_if,
// irc_lp_parse and irc_lp_outq.
//
// The parser accepts one received byte per cycle and turns each byte into
// zero to three result words (command code, parameter byte, parameter end,
// message end). Each byte is registered in the input register, and its words
// are registered in the result queue when it leaves, before they reach the
// output. Bytes pass through one input register and the parsing logic into
// an eight-word result queue that delivers one word per cycle while out_o is
// ready, so the byte rate is one per cycle as long as the bytes give no more
// than one word each on average. A byte waits in the input register, and the
// input stalls once that register is occupied, whenever the queue has fewer
// than three free slots, which a stalled consumer or a line end that emits
// several words can cause.
module irc_line_parser
  import irc_lp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  irc_lp_byte_if.sink   in_i,
  irc_lp_res_if.source  out_o
);

  push_t     push;
  q_status_t q_stat;

  irc_lp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  irc_lp_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .q_stat_o (q_stat),
    .out_o    (out_o)
  );

  // Words are only pushed when the queue has room for the worst case.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> q_stat.room)
    else $error("result words pushed into a queue without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= Q_LVL_W'(Q_DEPTH))
    else $error("result queue level beyond its depth");

  // Exactly the message end word carries the last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == (out_o.kind == KIND_MSG_END)))
    else $error("last flag does not match a message end word");

  // A three-word burst, which only a line end emits, finishes with the message end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd3) |-> (push.res[2].kind == KIND_MSG_END))
    else $error("three-word burst does not end in a message end");

endmodule
